// File: hdl/heading_pid_with_wrap_core_defines.svh
// Assertion macros shared by the heading PID core.
`ifndef HEADING_PID_WITH_WRAP_CORE_DEFINES_SVH
`define HEADING_PID_WITH_WRAP_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define HPW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HPW_ASSERT(label, clk, rst, prop, msg)
`define HPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: hdl/hpw_pkg.sv
`timescale 1ns / 1ps

package hpw_pkg;

   localparam int ANGLE_W = 9;
   localparam int DELTA_W = ANGLE_W + 1;
   localparam int ERR_W   = 11;
   localparam int WIDE_W  = ERR_W + 1;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int SUM_W   = 24;
   localparam int GAIN_W  = 16;
   localparam int LIM_W   = 15;
   localparam int CMD_W   = 16;
   localparam int P_W     = GAIN_W + ERR_W;
   localparam int I_W     = GAIN_W + SUM_W;
   localparam int D_W     = GAIN_W + DIFF_W;
   localparam int ACC_W   = I_W + 2;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic signed [DELTA_W-1:0] WRAP_POS  = 10'sd180;
   localparam logic signed [DELTA_W-1:0] WRAP_NEG  = -10'sd180;
   localparam logic signed [WIDE_W-1:0]  WRAP_SPAN = 12'sd360;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd90;
   localparam logic signed [GAIN_W-1:0] INT_GAIN_RST   = 16'sd0;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd384;
   localparam logic [LIM_W-1:0]         LIMIT_RST      = 15'd2560;

   typedef enum logic [1:0] {
      REG_PROP_GAIN,
      REG_INT_GAIN,
      REG_DERIV_GAIN,
      REG_OUTPUT_LIMIT
   } reg_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] int_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [LIM_W-1:0]         output_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [SUM_W-1:0]  sum;
      logic signed [DIFF_W-1:0] diff;
   } track_type;

   typedef struct packed {
      logic signed [P_W-1:0] p_term;
      logic signed [I_W-1:0] i_term;
      logic signed [D_W-1:0] d_term;
   } prod_type;

endpackage

// File: hdl/hpw_if.sv
`timescale 1ns / 1ps

interface hpw_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hpw_pkg::ANGLE_W-1:0]   measured_angle;
   logic signed [hpw_pkg::ANGLE_W-1:0]   target_angle;

   modport source (output valid, measured_angle, target_angle, input ready);
   modport sink (input valid, measured_angle, target_angle, output ready);
endinterface

interface hpw_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [hpw_pkg::CMD_W-1:0]   drive_command;
   logic                               clamped;

   modport source (output valid, drive_command, clamped, input ready);
   modport sink (input valid, drive_command, clamped, output ready);
endinterface

// File: hdl/hpw_csr.sv
`timescale 1ns / 1ps

module hpw_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [hpw_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [hpw_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [hpw_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output hpw_pkg::cfg_type             cfg
);

   hpw_pkg::cfg_type       cfg_ff;
   hpw_pkg::reg_index_type sel;
   logic                   wr_en;

   assign sel        = hpw_pkg::reg_index_type'(csr_paddr[hpw_pkg::CSR_AW-1:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= hpw_pkg::PROP_GAIN_RST;
         cfg_ff.int_gain     <= hpw_pkg::INT_GAIN_RST;
         cfg_ff.deriv_gain   <= hpw_pkg::DERIV_GAIN_RST;
         cfg_ff.output_limit <= hpw_pkg::LIMIT_RST;
      end else if (wr_en) begin
         case (sel)
            hpw_pkg::REG_PROP_GAIN: begin
               cfg_ff.prop_gain <= csr_pwdata[hpw_pkg::GAIN_W-1:0];
            end
            hpw_pkg::REG_INT_GAIN: begin
               cfg_ff.int_gain <= csr_pwdata[hpw_pkg::GAIN_W-1:0];
            end
            hpw_pkg::REG_DERIV_GAIN: begin
               cfg_ff.deriv_gain <= csr_pwdata[hpw_pkg::GAIN_W-1:0];
            end
            hpw_pkg::REG_OUTPUT_LIMIT: begin
               cfg_ff.output_limit <= csr_pwdata[hpw_pkg::LIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (sel)
         hpw_pkg::REG_PROP_GAIN: begin
            csr_prdata = hpw_pkg::CSR_DW'(cfg_ff.prop_gain);
         end
         hpw_pkg::REG_INT_GAIN: begin
            csr_prdata = hpw_pkg::CSR_DW'(cfg_ff.int_gain);
         end
         hpw_pkg::REG_DERIV_GAIN: begin
            csr_prdata = hpw_pkg::CSR_DW'(cfg_ff.deriv_gain);
         end
         hpw_pkg::REG_OUTPUT_LIMIT: begin
            csr_prdata = {{(hpw_pkg::CSR_DW - hpw_pkg::LIM_W){1'b0}}, cfg_ff.output_limit};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule

// File: hdl/hpw_track.sv
`timescale 1ns / 1ps
`include "heading_pid_with_wrap_core_defines.svh"

// Input register, then angle wrap, error, saturating sum and derivative.
// The error sum and previous error update as a request leaves the input register.
module hpw_track (
   input  logic                  clock,
   input  logic                  reset,
   hpw_req_if.sink               req,
   output logic                  trk_valid,
   input  logic                  trk_ready,
   output hpw_pkg::track_type    trk
);

   logic                                   a_valid_ff;
   logic signed [hpw_pkg::ANGLE_W-1:0]     meas_ff;
   logic signed [hpw_pkg::ANGLE_W-1:0]     targ_ff;
   logic                                   a_ready;
   logic                                   a_adv;

   logic                                   b_valid_ff;
   logic                                   b_ready;
   hpw_pkg::track_type                     trk_ff;
   hpw_pkg::track_type                     trk_in;

   logic signed [hpw_pkg::SUM_W-1:0]       sum_ff;
   logic signed [hpw_pkg::SUM_W-1:0]       sum_in;
   logic signed [hpw_pkg::ERR_W-1:0]       prev_err_ff;

   logic signed [hpw_pkg::DELTA_W-1:0]     delta;
   logic signed [hpw_pkg::WIDE_W-1:0]      err_raw;
   logic signed [hpw_pkg::WIDE_W-1:0]      err_adj;
   logic                                   wrap_lo;
   logic                                   wrap_hi;
   logic signed [hpw_pkg::ERR_W-1:0]       err_in;
   logic signed [hpw_pkg::SUM_W:0]         sum_ext;

   assign b_ready   = !b_valid_ff || trk_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign a_adv     = a_valid_ff && b_ready;
   assign req.ready = a_ready;
   assign trk_valid = b_valid_ff;
   assign trk       = trk_ff;

   always_comb begin
      delta   = $signed({meas_ff[hpw_pkg::ANGLE_W-1], meas_ff})
              - $signed({targ_ff[hpw_pkg::ANGLE_W-1], targ_ff});
      err_raw = $signed({{3{targ_ff[hpw_pkg::ANGLE_W-1]}}, targ_ff})
              - $signed({{3{meas_ff[hpw_pkg::ANGLE_W-1]}}, meas_ff});
      wrap_lo = (meas_ff <= 0) && (delta <= hpw_pkg::WRAP_NEG);
      wrap_hi = (meas_ff > 0) && (delta >= hpw_pkg::WRAP_POS);
      // Wrap shifts both angles by 180 in opposite directions: error moves by 360.
      if (wrap_lo) begin
         err_adj = err_raw - hpw_pkg::WRAP_SPAN;
      end else if (wrap_hi) begin
         err_adj = err_raw + hpw_pkg::WRAP_SPAN;
      end else begin
         err_adj = err_raw;
      end
      err_in  = err_adj[hpw_pkg::ERR_W-1:0];

      sum_ext = $signed({sum_ff[hpw_pkg::SUM_W-1], sum_ff})
              + $signed({{(hpw_pkg::SUM_W + 1 - hpw_pkg::ERR_W){err_in[hpw_pkg::ERR_W-1]}},
                         err_in});
      if (sum_ext[hpw_pkg::SUM_W] != sum_ext[hpw_pkg::SUM_W-1]) begin
         sum_in = sum_ext[hpw_pkg::SUM_W] ? hpw_pkg::SUM_MIN : hpw_pkg::SUM_MAX;
      end else begin
         sum_in = sum_ext[hpw_pkg::SUM_W-1:0];
      end

      trk_in.err  = err_in;
      trk_in.sum  = sum_in;
      trk_in.diff = $signed({err_in[hpw_pkg::ERR_W-1], err_in})
                  - $signed({prev_err_ff[hpw_pkg::ERR_W-1], prev_err_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && req.valid) begin
         meas_ff <= req.measured_angle;
         targ_ff <= req.target_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         sum_ff      <= '0;
         prev_err_ff <= '0;
      end else begin
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (a_adv) begin
            sum_ff      <= sum_in;
            prev_err_ff <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         trk_ff <= trk_in;
      end
   end

   `HPW_ASSERT_NEXT(a_state_follows, clock, reset, a_adv,
      (prev_err_ff == trk_ff.err) && (sum_ff == trk_ff.sum),
      "error state differs from the forwarded stage")
   `HPW_ASSERT_NEXT(a_sum_holds_max, clock, reset,
      a_adv && (sum_ff == hpw_pkg::SUM_MAX) && (err_in > 0),
      sum_ff == hpw_pkg::SUM_MAX, "error sum left positive saturation")

endmodule

// File: hdl/hpw_mult.sv
`timescale 1ns / 1ps

// Three gain multipliers in parallel, registered.
module hpw_mult (
   input  logic                  clock,
   input  logic                  reset,
   input  hpw_pkg::cfg_type      cfg,
   input  logic                  trk_valid,
   output logic                  trk_ready,
   input  hpw_pkg::track_type    trk,
   output logic                  prod_valid,
   input  logic                  prod_ready,
   output hpw_pkg::prod_type     prod
);

   logic                 c_valid_ff;
   hpw_pkg::prod_type    prod_ff;
   hpw_pkg::prod_type    prod_in;

   assign trk_ready  = !c_valid_ff || prod_ready;
   assign prod_valid = c_valid_ff;
   assign prod       = prod_ff;

   always_comb begin
      prod_in.p_term = $signed(cfg.prop_gain) * $signed(trk.err);
      prod_in.i_term = $signed(cfg.int_gain) * $signed(trk.sum);
      prod_in.d_term = $signed(cfg.deriv_gain) * $signed(trk.diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (trk_ready) begin
         c_valid_ff <= trk_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (trk_ready && trk_valid) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// File: hdl/hpw_clamp.sv
`timescale 1ns / 1ps
`include "heading_pid_with_wrap_core_defines.svh"

// Sum of the three terms, symmetric clamp, output register.
module hpw_clamp (
   input  logic                  clock,
   input  logic                  reset,
   input  hpw_pkg::cfg_type      cfg,
   input  logic                  prod_valid,
   output logic                  prod_ready,
   input  hpw_pkg::prod_type     prod,
   hpw_rsp_if.source             rsp
);

   logic                                  d_valid_ff;
   logic signed [hpw_pkg::CMD_W-1:0]      cmd_ff;
   logic signed [hpw_pkg::CMD_W-1:0]      cmd_in;
   logic                                  clamped_ff;
   logic                                  clamped_in;

   logic signed [hpw_pkg::ACC_W-1:0]      acc;
   logic signed [hpw_pkg::ACC_W-1:0]      lim_pos;
   logic signed [hpw_pkg::ACC_W-1:0]      lim_neg;
   logic signed [hpw_pkg::CMD_W-1:0]      lim16;

   assign prod_ready        = !d_valid_ff || rsp.ready;
   assign rsp.valid         = d_valid_ff;
   assign rsp.drive_command = cmd_ff;
   assign rsp.clamped       = clamped_ff;

   always_comb begin
      acc = $signed({{(hpw_pkg::ACC_W - hpw_pkg::P_W){prod.p_term[hpw_pkg::P_W-1]}},
                     prod.p_term})
          + $signed({{(hpw_pkg::ACC_W - hpw_pkg::I_W){prod.i_term[hpw_pkg::I_W-1]}},
                     prod.i_term})
          + $signed({{(hpw_pkg::ACC_W - hpw_pkg::D_W){prod.d_term[hpw_pkg::D_W-1]}},
                     prod.d_term});
      lim_pos = $signed({{(hpw_pkg::ACC_W - hpw_pkg::LIM_W){1'b0}}, cfg.output_limit});
      lim_neg = -lim_pos;
      lim16   = $signed({1'b0, cfg.output_limit});
      if (acc > lim_pos) begin
         cmd_in     = lim16;
         clamped_in = 1'b1;
      end else if (acc < lim_neg) begin
         cmd_in     = -lim16;
         clamped_in = 1'b1;
      end else begin
         cmd_in     = acc[hpw_pkg::CMD_W-1:0];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (prod_ready) begin
         d_valid_ff <= prod_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && prod_valid) begin
         cmd_ff     <= cmd_in;
         clamped_ff <= clamped_in;
      end
   end

   `HPW_ASSERT(a_clamp_at_limit, clock, reset,
      !(d_valid_ff && clamped_ff) || (cmd_ff == lim16) || (cmd_ff == -lim16),
      "clamped command is not at the limit")
   `HPW_ASSERT(a_free_within_limit, clock, reset,
      !(d_valid_ff && !clamped_ff) || ((cmd_ff <= lim16) && (cmd_ff >= -lim16)),
      "unclamped command lies outside the limit")

endmodule

// File: hdl/heading_pid_with_wrap_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// req_ch    in   valid/ready          measured_angle, target_angle (deg)
// rsp_ch    out  valid/ready          drive_command (Q.8), clamped
// csr_*     in   APB write/read       prop/int/deriv gain, output_limit
//
// One request per cycle sustained while rsp_ch is not stalled; each result passes four
// register stages, input register included, from the edge that accepts its request.
// The error-sum/previous-error loop sets throughput; it closes on its own registers.
// Synchronous reset clears the pipeline and error state, loads default gains and limit.
// A stalled rsp_ch holds its result; the stages ahead keep filling until all are full.

module heading_pid_with_wrap_core (
   input  logic                         clock,
   input  logic                         reset,
   hpw_req_if.sink                      req_ch,
   hpw_rsp_if.source                    rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [hpw_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [hpw_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [hpw_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   hpw_pkg::cfg_type      cfg;
   hpw_pkg::track_type    trk;
   hpw_pkg::prod_type     prod;
   logic                  trk_valid;
   logic                  trk_ready;
   logic                  prod_valid;
   logic                  prod_ready;

   hpw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hpw_track u_track (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .trk_valid (trk_valid),
      .trk_ready (trk_ready),
      .trk       (trk)
   );

   hpw_mult u_mult (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .trk_valid  (trk_valid),
      .trk_ready  (trk_ready),
      .trk        (trk),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   hpw_clamp u_clamp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod),
      .rsp        (rsp_ch)
   );

endmodule
